/* rtl/merge_two_sorted_lists_top_defines.svh */
// Assertion macros shared by the checker of the two-way merge block.
// Depends on nothing; the using module must have clk_i and rst_ni in scope.
`ifndef MERGE_TWO_SORTED_LISTS_TOP_DEFINES_SVH
`define MERGE_TWO_SORTED_LISTS_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MTSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("merge checker: implication failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MTSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("merge checker: next-cycle implication failed");

`endif

/* rtl/mtsl_pkg.sv */
// Types and constants of the two-way merge block.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package mtsl_pkg;

  // Capacity of each of the two stores (valid range 1 to 32).
  localparam int LIST_DEPTH = 32;
  localparam int VALUE_W    = 32;
  localparam int KIND_W     = 2;
  // Counts must also hold LIST_DEPTH itself; indexes run to LIST_DEPTH - 1.
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FIRST  = 2'd0,
    KIND_PUSH_SECOND = 2'd1,
    KIND_MERGE       = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] merged_value;
    logic                      last;
    logic                      overflow;
  } res_item_t;

endpackage

/* rtl/mtsl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module mtsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/merge_two_sorted_lists_top.sv */
// Top level of the two-way stable merge block: two stores, counts and sequencer.
// Depends on mtsl_pkg and mtsl_ram.
`timescale 1ns / 1ps

// Channel   | Ports                         | Handshake
// ----------+-------------------------------+------------------------------------
// input     | start_i, busy_o, in_i         | item taken when start_i && !busy_o
// result    | res_valid_o, res_o            | item shown for one cycle, no stall
//
// A push item leaves busy_o low, so pushes can follow back to back. A merge
// of n stored values holds busy_o high while it runs and delivers one result
// item per cycle, each through the res_q register. That rate is set by the
// single read port of each store and the one shared signed comparator. A
// merge with both stores empty gives no result. Reset empties both stores
// and clears the overflow flag; store contents are not cleared, since only
// entries below the fill count are ever read. The receiver cannot stall, so
// results are registered and never held.

module merge_two_sorted_lists_top
  import mtsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_item_t  in_i,
  output logic      res_valid_o,
  output res_item_t res_o
);

  state_e    state_q, state_d;
  logic [CNT_W-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
  logic      ovf_q, ovf_d;
  res_item_t res_q, res_d;
  logic      res_valid_q, res_valid_d;

  logic             accept;
  logic             we1, we2;
  logic [VALUE_W-1:0] rd1, rd2;
  logic             take_first;
  logic             run_done;

  assign accept = start_i && (state_q == ST_IDLE);

  // Each store has its own RAM. The read address follows the next head index,
  // so the heads of both stores are ready in the cycle the compare needs them.
  mtsl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (LIST_DEPTH)
  ) u_first_store (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (cnt1_q[IDX_W-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (i_d[IDX_W-1:0]),
    .rdata_o (rd1)
  );

  mtsl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (LIST_DEPTH)
  ) u_second_store (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (cnt2_q[IDX_W-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (j_d[IDX_W-1:0]),
    .rdata_o (rd2)
  );

  // The first store wins ties, which keeps the merge stable. Once a store is
  // exhausted the other one supplies the rest of the run.
  assign take_first = (i_q != cnt1_q) &&
                      ((j_q == cnt2_q) || ($signed(rd1) <= $signed(rd2)));

  // The run ends when the head that is taken now was the last one left.
  assign run_done = ((i_q + CNT_W'(take_first)) == cnt1_q) &&
                    ((j_q + CNT_W'(!take_first)) == cnt2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt1_q      <= cnt1_d;
      cnt2_q      <= cnt2_d;
      i_q         <= i_d;
      j_q         <= j_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt1_d      = cnt1_q;
    cnt2_d      = cnt2_q;
    i_d         = i_q;
    j_d         = j_q;
    ovf_d       = ovf_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    we1         = 1'b0;
    we2         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // Keep both heads at entry zero so a merge finds them already read.
        i_d = '0;
        j_d = '0;
        if (accept) begin
          unique case (kind_e'(in_i.kind))
            KIND_PUSH_FIRST: begin
              if (cnt1_q == CNT_W'(LIST_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                we1    = 1'b1;
                cnt1_d = cnt1_q + 1'b1;
              end
            end
            KIND_PUSH_SECOND: begin
              if (cnt2_q == CNT_W'(LIST_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                we2    = 1'b1;
                cnt2_d = cnt2_q + 1'b1;
              end
            end
            KIND_MERGE: begin
              if ((cnt1_q != '0) || (cnt2_q != '0)) begin
                state_d = ST_MERGE;
              end else begin
                ovf_d = 1'b0;
              end
            end
            default: begin
              // The unused kind code leaves all state as it is.
            end
          endcase
        end
      end
      ST_MERGE: begin
        i_d = i_q + CNT_W'(take_first);
        j_d = j_q + CNT_W'(!take_first);
        res_valid_d        = 1'b1;
        res_d.merged_value = take_first ? rd1 : rd2;
        res_d.last         = run_done;
        res_d.overflow     = ovf_q;
        if (run_done) begin
          state_d = ST_IDLE;
          cnt1_d  = '0;
          cnt2_d  = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/mtsl_checker.sv */
// Port-level checker of the two-way merge block, bound to the top level.
// Depends on mtsl_pkg and merge_two_sorted_lists_top_defines.svh.
`timescale 1ns / 1ps
`include "merge_two_sorted_lists_top_defines.svh"

module mtsl_checker
  import mtsl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input in_item_t  in_i,
  input logic      res_valid_o,
  input res_item_t res_o
);

  // A merged run has no gaps: every result but the last is followed by another.
  `MTSL_ASSERT_NXT(a_run_contiguous, res_valid_o && !res_o.last, res_valid_o)

  // While a run is still coming out, the block takes no new item.
  `MTSL_ASSERT_IMP(a_busy_in_run, res_valid_o && !res_o.last, busy_o)

  // The overflow flag is the same on every result of one run.
  `MTSL_ASSERT_IMP(a_ovf_stable,
    res_valid_o && $past(res_valid_o) && !$past(res_o.last),
    res_o.overflow == $past(res_o.overflow))

  // A new run cannot start output right after the previous run ended.
  `MTSL_ASSERT_NXT(a_gap_after_last, res_valid_o && res_o.last, !res_valid_o)

endmodule

bind merge_two_sorted_lists_top mtsl_checker u_mtsl_checker (.*);
